// ===== sv/sts_pkg.sv =====
// Package for the s-expression token scanner: token codes, character codes,
// limits and the token and run records passed between the scanner stages.
// No dependencies.
package sts_pkg;

  typedef enum logic [3:0] {
    TK_LPAREN     = 4'd0,
    TK_RPAREN     = 4'd1,
    TK_QUOTE      = 4'd2,
    TK_QUASIQUOTE = 4'd3,
    TK_UNQUOTE    = 4'd4,
    TK_DQUOTE     = 4'd5,
    TK_NUMBER     = 4'd6,
    TK_ATOM_CHAR  = 4'd7,
    TK_ATOM_END   = 4'd8,
    TK_EOF        = 4'd9
  } token_kind_e;

  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_BACKQUOTE = 8'h60;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_VT        = 8'h0B;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  localparam logic [7:0]  ATOM_MAX         = 8'd127;
  localparam logic [5:0]  NUMBER_MAX_CHARS = 6'd63;
  localparam logic [5:0]  COUNT6_MAX       = 6'd63;
  localparam logic [47:0] MANT_MAX         = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] DEPTH_MAX        = 16'h7FFF;
  localparam logic [15:0] DEPTH_MIN        = 16'h8000;

  typedef struct packed {
    token_kind_e kind;
    logic [47:0] mantissa;
    logic        negative;
    logic [5:0]  frac;
    logic [7:0]  abyte;
    logic        afirst;
    logic [7:0]  alen;
    logic        atrunc;
    logic [15:0] depth;
  } tok_t;

  typedef struct packed {
    logic [1:0]      count;
    tok_t [2:0]      tok;
  } run_t;

endpackage

// ===== sv/sts_in_if.sv =====
// Input channel of the s-expression token scanner: one character item.
// Depends on sts_pkg.
interface sts_in_if import sts_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== sv/sts_out_if.sv =====
// Output channel of the s-expression token scanner: one token item.
// Depends on sts_pkg.
interface sts_out_if import sts_pkg::*; ();
  logic               valid;
  logic               ready;
  token_kind_e        token_kind;
  logic [47:0]        number_mantissa;
  logic               number_negative;
  logic [5:0]         fraction_digits;
  logic [7:0]         atom_byte;
  logic               atom_first;
  logic [7:0]         atom_length;
  logic               atom_truncated;
  logic signed [15:0] paren_depth;
  logic               last_of_run;

  modport source (
    output valid, output token_kind, output number_mantissa, output number_negative,
    output fraction_digits, output atom_byte, output atom_first, output atom_length,
    output atom_truncated, output paren_depth, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input number_mantissa, input number_negative,
    input fraction_digits, input atom_byte, input atom_first, input atom_length,
    input atom_truncated, input paren_depth, input last_of_run, output ready
  );
endinterface

// ===== sv/sexpr_token_scanner.sv =====
// S-expression token scanner: takes one character item per cycle and gives
// Lisp tokens, one item per cycle, each carrying the paren depth after it.
// Depends on sts_pkg, sts_in_if, sts_out_if, sts_front, sts_queue, sts_back.
//
// The front end accepts a character in every cycle in which its run queue has
// room, and one character causes zero to three tokens. The output port delivers
// one token per cycle while ready, so a stream runs at one character per cycle
// as long as it averages at most one token per character; otherwise the output
// port sets the pace and the queue of QUEUE_DEPTH runs absorbs bursts. A token
// passes through the run queue and the serializer's run register on its way out.
module sexpr_token_scanner import sts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sts_in_if.sink    in_i,
  sts_out_if.source out_o
);

  logic push_valid, push_ready;
  run_t push_run;
  logic pop_valid, pop_ready;
  run_t pop_run;

  sts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_run_o   (push_run),
    .push_ready_i (push_ready)
  );

  sts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_run_i   (push_run),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_run_o    (pop_run),
    .pop_ready_i  (pop_ready)
  );

  sts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_run_i   (pop_run),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

// ===== sv/sts_front.sv =====
// Scanner front end: accepts one character item per cycle while the queue has room,
// updates the lexer state and pushes its run of up to three tokens. Needs sts_pkg.
module sts_front import sts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sts_in_if.sink in_i,
  output logic  push_valid_o,
  output run_t  push_run_o,
  input  logic  push_ready_i
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_ATOM   = 2'd2,
    MODE_MINUS  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [47:0] mant;
    logic        sign;
    logic [1:0]  dots;
    logic [5:0]  frac;
    logic [5:0]  nchars;
    logic [7:0]  acount;
    logic        aovf;
  } scan_t;

  typedef struct packed {
    scan_t       s;
    logic [15:0] depth;
    run_t        r;
  } ctx_t;

  localparam scan_t SCAN_CLEAR = '0;

  function automatic tok_t tok_plain(token_kind_e k, logic [15:0] d);
    tok_t t;
    t       = '0;
    t.kind  = k;
    t.depth = d;
    return t;
  endfunction

  function automatic ctx_t emit(ctx_t c, tok_t t);
    ctx_t x;
    x = c;
    if (x.r.count < 2'd3) begin
      x.r.tok[x.r.count] = t;
      x.r.count          = x.r.count + 2'd1;
    end
    return x;
  endfunction

  function automatic logic is_ws(logic [7:0] ch);
    return ch inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic ctx_t emit_number(ctx_t c);
    ctx_t x;
    tok_t t;
    x          = c;
    t          = tok_plain(TK_NUMBER, x.depth);
    t.mantissa = x.s.mant;
    t.negative = x.s.sign;
    t.frac     = x.s.frac;
    x          = emit(x, t);
    x.s        = SCAN_CLEAR;
    return x;
  endfunction

  function automatic ctx_t emit_atom_end(ctx_t c);
    ctx_t x;
    tok_t t;
    x        = c;
    t        = tok_plain(TK_ATOM_END, x.depth);
    t.alen   = x.s.acount;
    t.atrunc = x.s.aovf;
    x        = emit(x, t);
    x.s      = SCAN_CLEAR;
    return x;
  endfunction

  function automatic ctx_t atom_add(ctx_t c, logic [7:0] ch);
    ctx_t x;
    tok_t t;
    x = c;
    t = tok_plain(TK_ATOM_CHAR, x.depth);
    if (x.s.acount < ATOM_MAX) begin
      t.abyte    = ch;
      t.afirst   = (x.s.acount == 8'd0);
      x          = emit(x, t);
      x.s.acount = x.s.acount + 8'd1;
    end else begin
      x.s.aovf = 1'b1;
    end
    return x;
  endfunction

  function automatic ctx_t number_add(ctx_t c, logic [7:0] ch);
    ctx_t        x;
    logic [51:0] v;
    x = c;
    v = ({4'd0, x.s.mant} << 3) + ({4'd0, x.s.mant} << 1) + {48'd0, ch[3:0]};
    if (ch == CH_DOT) begin
      if (x.s.dots < 2'd2) x.s.dots = x.s.dots + 2'd1;
    end else if (x.s.dots < 2'd2) begin
      if (x.s.mant != MANT_MAX) begin
        if (v[51:48] != 4'd0) begin
          x.s.mant = MANT_MAX;
        end else begin
          x.s.mant = v[47:0];
          if (x.s.dots == 2'd1 && x.s.frac < COUNT6_MAX) x.s.frac = x.s.frac + 6'd1;
        end
      end
    end
    if (x.s.nchars < COUNT6_MAX) x.s.nchars = x.s.nchars + 6'd1;
    if (x.s.nchars >= NUMBER_MAX_CHARS) x = emit_number(x);
    return x;
  endfunction

  function automatic ctx_t scan_idle(ctx_t c, logic [7:0] ch);
    ctx_t x;
    x = c;
    if (!is_ws(ch)) begin
      case (ch)
        CH_LPAREN: begin
          if (x.depth != DEPTH_MAX) x.depth = x.depth + 16'd1;
          x = emit(x, tok_plain(TK_LPAREN, x.depth));
        end
        CH_RPAREN: begin
          if (x.depth != DEPTH_MIN) x.depth = x.depth - 16'd1;
          x = emit(x, tok_plain(TK_RPAREN, x.depth));
        end
        CH_QUOTE:     x = emit(x, tok_plain(TK_QUOTE, x.depth));
        CH_BACKQUOTE: x = emit(x, tok_plain(TK_QUASIQUOTE, x.depth));
        CH_COMMA:     x = emit(x, tok_plain(TK_UNQUOTE, x.depth));
        CH_DQUOTE:    x = emit(x, tok_plain(TK_DQUOTE, x.depth));
        CH_MINUS:     x.s.mode = MODE_MINUS;
        default: begin
          x.s = SCAN_CLEAR;
          if (is_digit(ch)) begin
            x.s.mode = MODE_NUMBER;
            x        = number_add(x, ch);
          end else begin
            x.s.mode = MODE_ATOM;
            x        = atom_add(x, ch);
          end
        end
      endcase
    end
    return x;
  endfunction

  scan_t       scan_q;
  logic [15:0] depth_q;
  ctx_t        ctx;
  logic        done;
  logic        accept;

  always_comb begin
    ctx.s     = scan_q;
    ctx.depth = depth_q;
    ctx.r     = '0;
    done      = 1'b0;
    if (in_i.end_of_input) begin
      case (scan_q.mode)
        MODE_NUMBER: ctx = emit_number(ctx);
        MODE_ATOM:   ctx = emit_atom_end(ctx);
        MODE_MINUS: begin
          ctx.s = SCAN_CLEAR;
          ctx   = atom_add(ctx, CH_MINUS);
          ctx   = emit_atom_end(ctx);
        end
        default: ;
      endcase
      ctx.s = SCAN_CLEAR;
      ctx   = emit(ctx, tok_plain(TK_EOF, ctx.depth));
    end else begin
      if (scan_q.mode == MODE_MINUS) begin
        ctx.s = SCAN_CLEAR;
        if (is_digit(in_i.in_byte)) begin
          ctx.s.mode   = MODE_NUMBER;
          ctx.s.sign   = 1'b1;
          ctx.s.nchars = 6'd1;
        end else begin
          ctx.s.mode = MODE_ATOM;
          ctx        = atom_add(ctx, CH_MINUS);
        end
      end
      if (ctx.s.mode == MODE_NUMBER) begin
        if (is_digit(in_i.in_byte) || in_i.in_byte == CH_DOT) begin
          ctx  = number_add(ctx, in_i.in_byte);
          done = 1'b1;
        end else begin
          ctx = emit_number(ctx);
        end
      end else if (ctx.s.mode == MODE_ATOM) begin
        if (!is_ws(in_i.in_byte) && in_i.in_byte != CH_RPAREN) begin
          ctx  = atom_add(ctx, in_i.in_byte);
          done = 1'b1;
        end else begin
          ctx = emit_atom_end(ctx);
        end
      end
      if (!done) ctx = scan_idle(ctx, in_i.in_byte);
    end
  end

  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && push_ready_i;
  assign push_valid_o = accept && (ctx.r.count != 2'd0);
  assign push_run_o   = ctx.r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= SCAN_CLEAR;
      depth_q <= '0;
    end else if (accept) begin
      scan_q  <= ctx.s;
      depth_q <= ctx.depth;
    end
  end

endmodule

// ===== sv/sts_queue.sv =====
// Run queue between the scanner front end and the token serializer.
// Depends on sts_pkg.
module sts_queue import sts_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  run_t push_run_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output run_t pop_run_o,
  input  logic pop_ready_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  run_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_run_o    = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/sts_back.sv =====
// Token serializer: holds one run in a register and presents its tokens one
// item per cycle on the output channel while it is ready. Depends on sts_pkg.
module sts_back import sts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  run_t       pop_run_i,
  output logic       pop_ready_o,
  sts_out_if.source  out_o
);

  run_t       run_q;
  logic [1:0] idx_q;
  logic       have_q;
  logic       last;
  logic       take;
  tok_t       tok;

  assign tok  = run_q.tok[idx_q];
  assign last = (idx_q == run_q.count - 2'd1);
  assign take = have_q && out_o.ready;
  assign pop_ready_o = !have_q || (take && last);

  assign out_o.valid           = have_q;
  assign out_o.token_kind      = tok.kind;
  assign out_o.number_mantissa = tok.mantissa;
  assign out_o.number_negative = tok.negative;
  assign out_o.fraction_digits = tok.frac;
  assign out_o.atom_byte       = tok.abyte;
  assign out_o.atom_first      = tok.afirst;
  assign out_o.atom_length     = tok.alen;
  assign out_o.atom_truncated  = tok.atrunc;
  assign out_o.paren_depth     = tok.depth;
  assign out_o.last_of_run     = last;

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      run_q <= pop_run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_valid_i && pop_ready_o) begin
      have_q <= 1'b1;
      idx_q  <= '0;
    end else if (take && last) begin
      have_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ===== tb/sv/tb_sexpr_token_scanner.sv =====
// Self-checking testbench for sexpr_token_scanner: drives characters, predicts
// the token stream in a scoreboard class and compares it with the output port.
// Depends on sts_pkg, sts_in_if, sts_out_if and the scanner RTL.
module tb_sexpr_token_scanner import sts_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_ATOM,
    SCAN_MINUS
  } scan_e;

  typedef struct packed {
    tok_t tok;
    logic last;
  } token_due_t;

  class token_tracker;
    scan_e              mode;
    logic [47:0]        mant;
    logic               neg;
    logic [1:0]         dots;
    logic [5:0]         frac;
    logic [5:0]         nchars;
    logic [7:0]         acount;
    logic               aover;
    logic signed [15:0] depth;
    tok_t               run_toks[$];
    token_due_t         due_tokens[$];
    int unsigned        errors;

    function new();
      clear_token();
      depth = '0;
      errors = 0;
    endfunction

    static function bit is_space(logic [7:0] ch);
      return ch inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    static function bit is_digit(logic [7:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function int unsigned pending();
      return due_tokens.size();
    endfunction

    function void clear_token();
      mode = SCAN_IDLE;
      mant = '0;
      neg = 1'b0;
      dots = '0;
      frac = '0;
      nchars = '0;
      acount = '0;
      aover = 1'b0;
    endfunction

    function tok_t blank(token_kind_e kind);
      tok_t t;
      t = '0;
      t.kind = kind;
      return t;
    endfunction

    function void push_token(tok_t t);
      t.depth = depth;
      if (run_toks.size() < 3) run_toks.push_back(t);
    endfunction

    function void close_number();
      tok_t t;
      t = blank(TK_NUMBER);
      t.mantissa = mant;
      t.negative = neg;
      t.frac = frac;
      push_token(t);
      clear_token();
    endfunction

    function void close_atom();
      tok_t t;
      t = blank(TK_ATOM_END);
      t.alen = acount;
      t.atrunc = aover;
      push_token(t);
      clear_token();
    endfunction

    function void atom_add(logic [7:0] ch);
      tok_t t;
      if (acount < ATOM_MAX) begin
        t = blank(TK_ATOM_CHAR);
        t.abyte = ch;
        t.afirst = (acount == 0);
        push_token(t);
        acount++;
      end else begin
        aover = 1'b1;
      end
    endfunction

    function void number_add(logic [7:0] ch);
      logic [63:0] widened;
      if (ch == CH_DOT) begin
        if (dots < 2) dots++;
      end else if (dots < 2 && mant != MANT_MAX) begin
        widened = 64'(mant) * 64'd10 + 64'(ch - CH_ZERO);
        if (widened > 64'(MANT_MAX)) begin
          mant = MANT_MAX;
        end else begin
          mant = widened[47:0];
          if (dots == 1 && frac < COUNT6_MAX) frac++;
        end
      end
      if (nchars < COUNT6_MAX) nchars++;
      if (nchars >= NUMBER_MAX_CHARS) close_number();
    endfunction

    function void scan_idle(logic [7:0] ch);
      if (is_space(ch)) return;
      case (ch)
        CH_LPAREN: begin
          if (depth != DEPTH_MAX) depth++;
          push_token(blank(TK_LPAREN));
        end
        CH_RPAREN: begin
          if (depth != DEPTH_MIN) depth--;
          push_token(blank(TK_RPAREN));
        end
        CH_QUOTE: push_token(blank(TK_QUOTE));
        CH_BACKQUOTE: push_token(blank(TK_QUASIQUOTE));
        CH_COMMA: push_token(blank(TK_UNQUOTE));
        CH_DQUOTE: push_token(blank(TK_DQUOTE));
        CH_MINUS: mode = SCAN_MINUS;
        default: begin
          clear_token();
          if (is_digit(ch)) begin
            mode = SCAN_NUMBER;
            number_add(ch);
          end else begin
            mode = SCAN_ATOM;
            atom_add(ch);
          end
        end
      endcase
    endfunction

    // Returns 1 when the character did more than get skipped as idle whitespace.
    function bit take_char(logic [7:0] ch, logic eoi);
      bit    done;
      scan_e was;
      was = mode;
      done = 1'b0;
      run_toks.delete();
      if (eoi) begin
        case (mode)
          SCAN_NUMBER: close_number();
          SCAN_ATOM: close_atom();
          SCAN_MINUS: begin
            clear_token();
            atom_add(CH_MINUS);
            close_atom();
          end
          default: ;
        endcase
        clear_token();
        push_token(blank(TK_EOF));
      end else begin
        if (mode == SCAN_MINUS) begin
          clear_token();
          if (is_digit(ch)) begin
            mode = SCAN_NUMBER;
            neg = 1'b1;
            nchars = 6'd1;
          end else begin
            mode = SCAN_ATOM;
            atom_add(CH_MINUS);
          end
        end
        if (mode == SCAN_NUMBER) begin
          if (is_digit(ch) || ch == CH_DOT) begin
            number_add(ch);
            done = 1'b1;
          end else begin
            close_number();
          end
        end else if (mode == SCAN_ATOM) begin
          if (!is_space(ch) && ch != CH_RPAREN) begin
            atom_add(ch);
            done = 1'b1;
          end else begin
            close_atom();
          end
        end
        if (!done) scan_idle(ch);
      end
      foreach (run_toks[i]) begin
        due_tokens.push_back('{tok: run_toks[i], last: (i == run_toks.size() - 1)});
      end
      return run_toks.size() != 0 || was != SCAN_IDLE || mode != SCAN_IDLE;
    endfunction

    function void compare(string field, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void match_token(tok_t got, logic last);
      token_due_t want;
      if (due_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none got kind %0d", $time, got.kind);
        errors++;
        return;
      end
      want = due_tokens.pop_front();
      compare("token_kind", want.tok.kind, got.kind);
      compare("number_mantissa", want.tok.mantissa, got.mantissa);
      compare("number_negative", want.tok.negative, got.negative);
      compare("fraction_digits", want.tok.frac, got.frac);
      compare("atom_byte", want.tok.abyte, got.abyte);
      compare("atom_first", want.tok.afirst, got.afirst);
      compare("atom_length", want.tok.alen, got.alen);
      compare("atom_truncated", want.tok.atrunc, got.atrunc);
      compare("paren_depth", want.tok.depth, got.depth);
      compare("last_of_run", want.last, last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_len;
  int unsigned active_items;
  int unsigned cycles;
  logic [7:0]  specials [6] = '{CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_BACKQUOTE,
                                CH_COMMA, CH_DQUOTE};
  logic [7:0]  spaces [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  token_tracker tracker = new();

  sts_in_if  in_if ();
  sts_out_if out_if ();

  sexpr_token_scanner uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_sexpr_token_scanner: errors");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    hold_len = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    tok_t seen;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        seen = '{kind: out_if.token_kind, mantissa: out_if.number_mantissa,
                 negative: out_if.number_negative, frac: out_if.fraction_digits,
                 abyte: out_if.atom_byte, afirst: out_if.atom_first,
                 alen: out_if.atom_length, atrunc: out_if.atom_truncated,
                 depth: out_if.paren_depth};
        tracker.match_token(seen, out_if.last_of_run);
      end
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= ch;
    in_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (tracker.take_char(ch, eoi)) active_items++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
  endtask

  function automatic logic [7:0] atom_body_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (token_tracker::is_space(ch) || ch == CH_RPAREN);
    return ch;
  endfunction

  task automatic send_terminator();
    case ($urandom_range(5))
      0, 1: send_char(spaces[$urandom_range(5)], 1'b0);
      2: send_char(CH_RPAREN, 1'b0);
      3: send_char(8'($urandom_range(255)), 1'b1);
      4: send_char(8'($urandom_range(255)), 1'b0);
      default: ;
    endcase
  endtask

  task automatic send_word();
    int unsigned pick;
    int unsigned len;
    int unsigned dot_pct;
    logic [7:0]  ch;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_char(specials[$urandom_range(5)], 1'b0);
    end else if (pick < 35) begin
      if ($urandom_range(2) == 0) send_char(CH_MINUS, 1'b0);
      dot_pct = $urandom_range(1) ? 0 : 12;
      len = ($urandom_range(11) == 0) ? $urandom_range(70, 14) : $urandom_range(7);
      send_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      repeat (len) begin
        ch = ($urandom_range(99) < dot_pct) ? CH_DOT : CH_ZERO + 8'($urandom_range(9));
        send_char(ch, 1'b0);
      end
      send_terminator();
    end else if (pick < 60) begin
      do ch = 8'($urandom_range(255));
      while (token_tracker::is_space(ch) || token_tracker::is_digit(ch) ||
             ch inside {CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_BACKQUOTE, CH_COMMA,
                        CH_DQUOTE, CH_MINUS});
      send_char(ch, 1'b0);
      len = ($urandom_range(14) == 0) ? $urandom_range(140, 120) : $urandom_range(9);
      repeat (len) send_char(atom_body_char(), 1'b0);
      send_terminator();
    end else if (pick < 70) begin
      send_char(CH_MINUS, 1'b0);
      case ($urandom_range(3))
        0: send_char(atom_body_char(), 1'b0);
        1: send_char(spaces[$urandom_range(5)], 1'b0);
        2: send_char(CH_RPAREN, 1'b0);
        default: send_char(8'($urandom_range(255)), 1'b1);
      endcase
    end else if (pick < 80) begin
      send_char(spaces[$urandom_range(5)], 1'b0);
    end else if (pick < 85) begin
      send_char(8'($urandom_range(255)), 1'b1);
    end else begin
      send_char(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic send_words(input int unsigned target);
    int unsigned start;
    start = active_items;
    while (active_items - start < target) send_word();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.end_of_input = 1'b0;
    active_items = 0;
    send_idle_pct = 30;
    recv_idle_pct = 88;
    @(posedge rst_ni);
    @(negedge clk_i);

    // Every single-character token, a negative fraction, an atom opened by a lone
    // minus that swallows a paren, a number with a second dot, the byte extremes as
    // atom characters, and end of input after a minus, when idle and after a number.
    foreach (specials[i]) send_char(specials[i], 1'b0);
    send_text("-12.5 -x()0..9");
    send_char(CH_TAB, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(8'hA5, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(CH_ZERO + 8'd7, 1'b0);
    send_char(8'hFF, 1'b1);

    send_words(60);
    hold_len = 300;
    send_words(100);
    drain();

    send_idle_pct = 88;
    recv_idle_pct = 30;
    send_words(160);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_words(160);
    send_char(CH_LPAREN, 1'b0);
    send_char(8'h00, 1'b1);

    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_sexpr_token_scanner: clean");
    end else begin
      $display("tb_sexpr_token_scanner: errors");
    end
    $finish;
  end

endmodule
